FILE: rtl/dtc_pkg.sv
// Shared types and constants of the dense triad counter.
package dtc_pkg;

   localparam int TYPE_W    = 2;
   localparam int ACTOR_W   = 6;
   localparam int DIFF_W    = 4;
   localparam int THR_W     = 3;
   localparam int COUNT_W   = 11;
   localparam int CONTRIB_W = 15;

   localparam logic [THR_W-1:0]   THRESHOLD_RESET = 3'd6;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = 11'd2047;

   // Request codes; code 3 carries no meaning and is dropped.
   typedef enum logic [TYPE_W-1:0] {
      REQ_SET   = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_QUERY = 2'd2
   } req_code_type;

   // Strobes from the sequencer to the triad lane.
   typedef struct packed {
      logic clear;     // new query: zero the accumulator
      logic load_ego;  // read data holds the ego row and column
      logic scan;      // read data holds the row and column of one alter
   } lane_ctrl_type;

endpackage

FILE: rtl/dtc_req_if.sv
// Request channel of the dense triad counter.
interface dtc_req_if;
   logic                              valid;
   logic                              ready;
   logic [dtc_pkg::TYPE_W-1:0]        req_type;
   logic [dtc_pkg::ACTOR_W-1:0]       tie_sender;
   logic [dtc_pkg::ACTOR_W-1:0]       tie_receiver;
   logic [dtc_pkg::ACTOR_W-1:0]       ego;
   logic signed [dtc_pkg::DIFF_W-1:0] difference;

   modport source(output valid, output req_type, output tie_sender, output tie_receiver,
                  output ego, output difference, input ready);
   modport sink(input valid, input req_type, input tie_sender, input tie_receiver,
                input ego, input difference, output ready);
endinterface

FILE: rtl/dtc_rsp_if.sv
// Response channel of the dense triad counter.
interface dtc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [dtc_pkg::COUNT_W-1:0]          triad_count;
   logic signed [dtc_pkg::CONTRIB_W-1:0] change_contribution;

   modport source(output valid, output triad_count, output change_contribution,
                  input ready);
   modport sink(input valid, input triad_count, input change_contribution,
                output ready);
endinterface

FILE: rtl/dtc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dtc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/dtc_triad_lane.sv
// Triad lane: dense-pair flags for one alter, popcount and saturating count.
module dtc_triad_lane #(
   parameter int ACTORS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dtc_pkg::lane_ctrl_type           ctrl,
   input  logic [dtc_pkg::THR_W-1:0]        threshold,
   input  logic [ACTORS-1:0]                row_q,
   input  logic [ACTORS-1:0]                col_q,
   input  logic [$clog2(ACTORS)-1:0]        j_index,
   input  logic [$clog2(ACTORS)-1:0]        ego_index,
   output logic [dtc_pkg::COUNT_W-1:0]      count,
   output logic                             busy
);

   localparam int PW = $clog2(ACTORS + 1);
   localparam int SW = ((PW > dtc_pkg::COUNT_W) ? PW : dtc_pkg::COUNT_W) + 1;

   logic [ACTORS-1:0]           ego_out_ff;
   logic [ACTORS-1:0]           ego_in_ff;
   logic [ACTORS-1:0]           ind_ff;
   logic                        indv_ff;
   logic [PW-1:0]               pc_ff;
   logic                        pcv_ff;
   logic [dtc_pkg::COUNT_W-1:0] acc_ff;
   logic [dtc_pkg::COUNT_W-1:0] acc_in;
   logic [ACTORS-1:0]           ind_vec;
   logic [1:0]                  ej;
   logic [SW-1:0]               sum;

   function automatic logic [PW-1:0] popcount(input logic [ACTORS-1:0] v);
      logic [PW-1:0] n;
      n = '0;
      for (int i = 0; i < ACTORS; i++) begin
         n = n + PW'(v[i]);
      end
      return n;
   endfunction

   // Flag every partner h above the alter whose triad with the ego is dense.
   always_comb begin
      logic [1:0] eh;
      logic [1:0] jh;
      logic [2:0] total;
      ej = {1'b0, ego_out_ff[j_index]} + {1'b0, ego_in_ff[j_index]};
      for (int h = 0; h < ACTORS; h++) begin
         eh       = {1'b0, ego_out_ff[h]} + {1'b0, ego_in_ff[h]};
         jh       = {1'b0, row_q[h]} + {1'b0, col_q[h]};
         total    = {1'b0, ej} + {1'b0, eh} + {1'b0, jh};
         ind_vec[h] = (total >= threshold) && (h > int'(j_index)) &&
                      (h != int'(ego_index)) && (j_index != ego_index);
      end
   end

   always_comb begin
      sum = SW'(acc_ff) + SW'(pc_ff);
      if (sum > SW'(dtc_pkg::COUNT_MAX)) begin
         acc_in = dtc_pkg::COUNT_MAX;
      end else begin
         acc_in = sum[dtc_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_ego) begin
         ego_out_ff <= row_q;
         ego_in_ff  <= col_q;
      end
      ind_ff <= ind_vec;
      pc_ff  <= popcount(ind_ff);
      if (reset) begin
         indv_ff <= 1'b0;
         pcv_ff  <= 1'b0;
         acc_ff  <= '0;
      end else begin
         indv_ff <= ctrl.scan;
         pcv_ff  <= indv_ff;
         if (ctrl.clear) begin
            acc_ff <= '0;
         end else if (pcv_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   assign count = acc_ff;
   assign busy  = indv_ff | pcv_ff;

endmodule

FILE: rtl/dense_triad_counter_unit.sv
// Top level of the dense triad counter: sequencer, tie memories and response register.
//
//   port     dir  handshake        contents
//   req      in   valid / ready    req_type, tie_sender, tie_receiver, ego, difference
//   rsp      out  valid / ready    triad_count, change_contribution (queries only)
//   csr_*    in   write enable     dense_threshold, 3 bits
//
// A set or clear request passes accept, read and write back; one with an actor
// at or beyond ACTORS ends at accept. A query passes accept, one memory read for
// the ego, one read of a row and a column per alter, a drain (read data, flag,
// popcount, accumulate) and the response load; an ego out of range goes from
// accept straight to the response load. No clearing pass: each memory row has a
// valid bit that reset clears, so the block takes requests from the first cycle after
// reset. A stalled response holds the sequencer only at the end of the next query.
module dense_triad_counter_unit #(
   parameter int ACTORS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   dtc_req_if.sink                     req,
   dtc_rsp_if.source                   rsp,
   input  logic                        csr_write_enable,
   input  logic [dtc_pkg::THR_W-1:0]   csr_write_data
);

   localparam int AW = $clog2(ACTORS);
   localparam logic [AW-1:0] LAST_ACTOR = AW'(ACTORS - 1);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_UPD_RD  = 7'b0000010,
      ST_UPD_WR  = 7'b0000100,
      ST_Q_EGO   = 7'b0001000,
      ST_Q_SCAN  = 7'b0010000,
      ST_Q_DRAIN = 7'b0100000,
      ST_Q_DONE  = 7'b1000000
   } state_type;

   state_type                          state_ff, state_in;
   logic [dtc_pkg::THR_W-1:0]          thr_ff;
   logic                               set_ff;
   logic [AW-1:0]                      snd_ff, rcv_ff, ego_ff;
   logic signed [dtc_pkg::DIFF_W-1:0]  diff_ff;
   logic [AW-1:0]                      j_ff, j_in;
   logic                               rd_ego_ff, rd_scan_ff;
   logic [AW-1:0]                      rd_j_ff;
   logic [ACTORS-1:0]                  row_valid_ff, col_valid_ff;
   logic [AW-1:0]                      row_raddr_q_ff, col_raddr_q_ff;
   logic                               rsp_valid_ff;
   logic [dtc_pkg::COUNT_W-1:0]        rsp_count_ff;
   logic signed [dtc_pkg::CONTRIB_W-1:0] rsp_contrib_ff;

   logic                               accept;
   logic                               ego_ok, tie_ok;
   logic                               is_query, is_update;
   logic                               rsp_load;
   logic [AW-1:0]                      row_raddr, col_raddr;
   logic [ACTORS-1:0]                  row_rdata, col_rdata;
   logic [ACTORS-1:0]                  row_q, col_q;
   logic [ACTORS-1:0]                  row_wdata, col_wdata;
   logic                               mem_we;
   logic [dtc_pkg::COUNT_W-1:0]        lane_count;
   logic                               lane_busy;
   dtc_pkg::lane_ctrl_type             lane_ctrl;
   logic signed [15:0]                 diff_ext, count_ext, product;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign ego_ok    = 32'(req.ego) < ACTORS;
   assign tie_ok    = (32'(req.tie_sender) < ACTORS) && (32'(req.tie_receiver) < ACTORS);
   assign is_query  = (req.req_type == dtc_pkg::REQ_QUERY);
   assign is_update = (req.req_type == dtc_pkg::REQ_SET) ||
                      (req.req_type == dtc_pkg::REQ_CLEAR);
   assign rsp_load  = (state_ff == ST_Q_DONE) && (!rsp_valid_ff || rsp.ready);

   // Sequencer: pick the next state and the alter counter.
   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req.req_type)
                  dtc_pkg::REQ_SET, dtc_pkg::REQ_CLEAR: begin
                     if (tie_ok) begin
                        state_in = ST_UPD_RD;
                     end
                  end
                  dtc_pkg::REQ_QUERY: begin
                     state_in = ego_ok ? ST_Q_EGO : ST_Q_DONE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_UPD_RD: state_in = ST_UPD_WR;
         ST_UPD_WR: state_in = ST_IDLE;
         ST_Q_EGO: begin
            state_in = ST_Q_SCAN;
            j_in     = '0;
         end
         ST_Q_SCAN: begin
            // Issue one alter a cycle; the last issue moves to the drain.
            if (j_ff == LAST_ACTOR) begin
               state_in = ST_Q_DRAIN;
            end else begin
               j_in = j_ff + AW'(1);
            end
         end
         ST_Q_DRAIN: begin
            if (!rd_scan_ff && !lane_busy) begin
               state_in = ST_Q_DONE;
            end
         end
         ST_Q_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Read addresses: row memory holds out-ties, column memory holds in-ties.
   always_comb begin
      case (state_ff)
         ST_UPD_RD: begin
            row_raddr = snd_ff;
            col_raddr = rcv_ff;
         end
         ST_Q_EGO: begin
            row_raddr = ego_ff;
            col_raddr = ego_ff;
         end
         default: begin
            row_raddr = j_ff;
            col_raddr = j_ff;
         end
      endcase
   end

   // A row never written reads as no ties.
   assign row_q = row_valid_ff[row_raddr_q_ff] ? row_rdata : '0;
   assign col_q = col_valid_ff[col_raddr_q_ff] ? col_rdata : '0;

   // Write back the read row and column with the one tie changed.
   always_comb begin
      row_wdata         = row_q;
      col_wdata         = col_q;
      row_wdata[rcv_ff] = set_ff;
      col_wdata[snd_ff] = set_ff;
   end
   assign mem_we = (state_ff == ST_UPD_WR);

   dtc_ram #(
      .WIDTH(ACTORS),
      .DEPTH(ACTORS)
   ) u_row_ram (
      .clock(clock),
      .we   (mem_we),
      .waddr(snd_ff),
      .wdata(row_wdata),
      .raddr(row_raddr),
      .rdata(row_rdata)
   );

   dtc_ram #(
      .WIDTH(ACTORS),
      .DEPTH(ACTORS)
   ) u_col_ram (
      .clock(clock),
      .we   (mem_we),
      .waddr(rcv_ff),
      .wdata(col_wdata),
      .raddr(col_raddr),
      .rdata(col_rdata)
   );

   assign lane_ctrl.clear    = accept && is_query;
   assign lane_ctrl.load_ego = rd_ego_ff;
   assign lane_ctrl.scan     = rd_scan_ff;

   dtc_triad_lane #(
      .ACTORS(ACTORS)
   ) u_lane (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (lane_ctrl),
      .threshold(thr_ff),
      .row_q    (row_q),
      .col_q    (col_q),
      .j_index  (rd_j_ff),
      .ego_index(ego_ff),
      .count    (lane_count),
      .busy     (lane_busy)
   );

   // Contribution: at worst -8 * 2047, so it always fits 15 bits.
   assign diff_ext  = 16'(diff_ff);
   assign count_ext = signed'({5'b00000, lane_count});
   assign product   = diff_ext * count_ext;

   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff  <= (req.req_type == dtc_pkg::REQ_SET);
         snd_ff  <= AW'(req.tie_sender);
         rcv_ff  <= AW'(req.tie_receiver);
         ego_ff  <= AW'(req.ego);
         diff_ff <= req.difference;
      end
      rd_j_ff        <= j_ff;
      row_raddr_q_ff <= row_raddr;
      col_raddr_q_ff <= col_raddr;
      if (rsp_load) begin
         rsp_count_ff   <= lane_count;
         rsp_contrib_ff <= product[dtc_pkg::CONTRIB_W-1:0];
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= dtc_pkg::THRESHOLD_RESET;
         j_ff         <= '0;
         rd_ego_ff    <= 1'b0;
         rd_scan_ff   <= 1'b0;
         row_valid_ff <= '0;
         col_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         j_ff       <= j_in;
         rd_ego_ff  <= (state_ff == ST_Q_EGO);
         rd_scan_ff <= (state_ff == ST_Q_SCAN);
         if (csr_write_enable) begin
            thr_ff <= csr_write_data;
         end
         if (mem_we) begin
            row_valid_ff[snd_ff] <= 1'b1;
            col_valid_ff[rcv_ff] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.triad_count         = rsp_count_ff;
   assign rsp.change_contribution = rsp_contrib_ff;

   // An in-range set or clear reaches the write-back through the read state.
   a_update_writes: assert property (@(posedge clock) disable iff (reset)
      (accept && is_update && tie_ok) |=> ##1 (state_ff == ST_UPD_WR))
      else $error("tie update did not reach write-back");

   // An in-range query starts with the ego read.
   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && is_query && ego_ok) |=> (state_ff == ST_Q_EGO))
      else $error("query did not start with the ego read");

   // Alter data only arrives while a query scans or drains.
   a_scan_window: assert property (@(posedge clock) disable iff (reset)
      rd_scan_ff |-> (state_ff == ST_Q_SCAN || state_ff == ST_Q_DRAIN))
      else $error("alter data outside a query");

   // A zero count carries a zero contribution.
   a_zero_contrib: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_count_ff == '0) |-> (rsp_contrib_ff == '0))
      else $error("non-zero contribution with zero count");

endmodule

FILE: tb/tb_dense_triad_counter_unit.sv
// Self-checking testbench for the dense triad counter: random and directed requests, scoreboard.
module tb_dense_triad_counter_unit;
   import dtc_pkg::*;

   localparam int ACTORS          = 64;
   // Request code with no meaning; the block drops it without a response.
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
   // Longest request is a query, which scans all ACTORS alters; allow margin over it.
   localparam int QUIET_CYCLES    = ACTORS + 16;
   localparam int CYCLE_LIMIT     = 900000;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int REPORT_LINES    = 200;
   localparam int CHUNKS          = 12;
   localparam int CHUNK_REQUESTS  = 120;

   typedef struct {
      logic [COUNT_W-1:0]          count;
      logic signed [CONTRIB_W-1:0] contribution;
   } triad_tally_type;

   // Mirror of the tie matrix and threshold, plus the queue of tallies owed by the block.
   class triad_tally_ledger;
      logic [ACTORS-1:0] tie_rows [ACTORS];
      logic [THR_W-1:0]  threshold;
      triad_tally_type   expected_tallies [$];
      int                mismatches;

      function void clear_state();
         foreach (tie_rows[i]) tie_rows[i] = '0;
         threshold = THRESHOLD_RESET;
         expected_tallies.delete();
         mismatches = 0;
      endfunction

      function int ties_between(int a, int b);
         return int'(tie_rows[a][b]) + int'(tie_rows[b][a]);
      endfunction

      // Count unordered alter pairs whose triad with the ego reaches the threshold.
      function int count_dense_triads(int ego_id);
         int ego_ties [ACTORS];
         int count;
         count = 0;
         for (int a = 0; a < ACTORS; a++) ego_ties[a] = ties_between(ego_id, a);
         for (int j = 0; j < ACTORS; j++) begin
            for (int h = j + 1; h < ACTORS; h++) begin
               if (j != ego_id && h != ego_id &&
                   ego_ties[j] + ego_ties[h] + ties_between(j, h) >= int'(threshold))
                  count++;
            end
         end
         return count;
      endfunction

      function void note_request(input logic [TYPE_W-1:0] kind,
                                 input logic [ACTOR_W-1:0] sender, receiver, ego_id,
                                 input logic signed [DIFF_W-1:0] diff);
         triad_tally_type tally;
         int              count;
         int              contribution;
         if (kind == REQ_SET || kind == REQ_CLEAR) begin
            if (int'(sender) < ACTORS && int'(receiver) < ACTORS)
               tie_rows[sender][receiver] = (kind == REQ_SET);
         end else if (kind == REQ_QUERY) begin
            count = (int'(ego_id) < ACTORS) ? count_dense_triads(ego_id) : 0;
            if (count > int'(COUNT_MAX)) count = int'(COUNT_MAX);
            contribution = int'(diff) * count;
            if (contribution > 16383) contribution = 16383;
            if (contribution < -16384) contribution = -16384;
            tally.count        = COUNT_W'(count);
            tally.contribution = CONTRIB_W'(contribution);
            expected_tallies.push_back(tally);
         end
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         if (mismatches <= REPORT_LINES) $display("mismatch: %s", what);
      endtask

      task check_result(input logic [COUNT_W-1:0] got_count,
                        input logic signed [CONTRIB_W-1:0] got_contribution);
         triad_tally_type want;
         if (expected_tallies.size() == 0) begin
            report_mismatch($sformatf("response with none outstanding (count %0d, contrib %0d)",
                                      got_count, got_contribution));
            return;
         end
         want = expected_tallies.pop_front();
         if (got_count !== want.count)
            report_mismatch($sformatf("triad_count got %0d expected %0d",
                                      got_count, want.count));
         if (got_contribution !== want.contribution)
            report_mismatch($sformatf("change_contribution got %0d expected %0d",
                                      got_contribution, want.contribution));
      endtask

      function int outstanding();
         return expected_tallies.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [THR_W-1:0]  csr_write_data;

   dtc_req_if req_ch ();
   dtc_rsp_if rsp_ch ();

   triad_tally_ledger ledger;

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int hold_off_len   = 0;
   int requests_sent  = 0;
   int cycle_count    = 0;

   // Threshold per random chunk: the intended 5 and 6 most often, every code at least once.
   logic [THR_W-1:0] threshold_plan [CHUNKS] =
      '{3'd5, 3'd0, 3'd6, 3'd7, 3'd6, 3'd5, 3'd3, 3'd1, 3'd5, 3'd2, 3'd4, 3'd6};

   dense_triad_counter_unit #(
      .ACTORS(ACTORS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: end the run if the block hangs or crawls.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_dense_triad_counter_unit: FAIL");
         $finish;
      end
   end

   // Response ready: random back-pressure, or a long hold-off when the stimulus asks for one.
   initial begin
      int stall_left;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_off_len != 0) begin
            stall_left   = hold_off_len;
            hold_off_len = 0;
            rsp_ch.ready <= 1'b0;
            repeat (stall_left) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Check every response taken by the handshake against the oldest owed tally.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         ledger.check_result(rsp_ch.triad_count, rsp_ch.change_contribution);
   end

   // Offer one request, idling at random first, and hold it until the block takes it.
   task automatic send_request(input logic [TYPE_W-1:0] kind,
                               input logic [ACTOR_W-1:0] sender, receiver, ego_id,
                               input logic signed [DIFF_W-1:0] diff);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= kind;
      req_ch.tie_sender   <= sender;
      req_ch.tie_receiver <= receiver;
      req_ch.ego          <= ego_id;
      req_ch.difference   <= diff;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      ledger.note_request(kind, sender, receiver, ego_id, diff);
      if (kind != REQ_UNUSED) requests_sent++;
   endtask

   // Drop valid, wait for every owed response, then let the sequencer run dry.
   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      ledger.threshold = value;
      csr_write_enable <= 1'b0;
   endtask

   // Favour a small pool of actors so that ties pile up and dense triads appear.
   function automatic logic [ACTOR_W-1:0] pick_actor();
      if ($urandom_range(99) < 70) return ACTOR_W'($urandom_range(15));
      return ACTOR_W'($urandom_range(ACTORS - 1));
   endfunction

   function automatic logic signed [DIFF_W-1:0] random_difference();
      return DIFF_W'($urandom_range(15));
   endfunction

   function automatic logic [ACTOR_W-1:0] any_actor();
      return ACTOR_W'($urandom_range(63));
   endfunction

   // Build a near-clique among a few distinct actors, then query some of its members.
   task automatic send_clique();
      logic [ACTOR_W-1:0] members [6];
      int                 size;
      bit                 fresh;
      size = $urandom_range(3, 6);
      for (int m = 0; m < size; m++) begin
         do begin
            members[m] = pick_actor();
            fresh = 1'b1;
            for (int p = 0; p < m; p++) if (members[p] == members[m]) fresh = 1'b0;
         end while (!fresh);
      end
      for (int a = 0; a < size; a++) begin
         for (int b = 0; b < size; b++) begin
            if (a != b && $urandom_range(99) < 85)
               send_request(REQ_SET, members[a], members[b], any_actor(), random_difference());
         end
      end
      repeat ($urandom_range(1, 3))
         send_request(REQ_QUERY, any_actor(), any_actor(), members[$urandom_range(size - 1)],
                      random_difference());
   endtask

   task automatic send_random_request();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         send_clique();
      end else if (pick < 75) begin
         send_request(REQ_QUERY, any_actor(), any_actor(), pick_actor(), random_difference());
      end else if (pick < 90) begin
         send_request(REQ_CLEAR, pick_actor(), pick_actor(), any_actor(), random_difference());
      end else begin
         // Noise: any code, the dropped one included, with every field random.
         send_request(TYPE_W'($urandom_range(3)), any_actor(), any_actor(), any_actor(),
                      random_difference());
      end
   endtask

   initial begin
      int chunk_end;
      ledger = new;
      ledger.clear_state();
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.req_type     <= REQ_SET;
      req_ch.tie_sender   <= '0;
      req_ch.tie_receiver <= '0;
      req_ch.ego          <= '0;
      req_ch.difference   <= '0;
      csr_write_enable    <= 1'b0;
      csr_write_data      <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: one full triad among the lowest and highest actors, reset threshold of six.
      send_request(REQ_SET, 6'd0,  6'd1,  6'd0, 4'sd0);
      send_request(REQ_SET, 6'd1,  6'd0,  6'd0, 4'sd0);
      send_request(REQ_SET, 6'd0,  6'd63, 6'd0, 4'sd0);
      send_request(REQ_SET, 6'd63, 6'd0,  6'd0, 4'sd0);
      send_request(REQ_SET, 6'd1,  6'd63, 6'd0, 4'sd0);
      send_request(REQ_SET, 6'd63, 6'd1,  6'd0, 4'sd0);
      // Self ties are stored but must never count.
      send_request(REQ_SET, 6'd5,  6'd5,  6'd0, 4'sd0);
      send_request(REQ_SET, 6'd0,  6'd0,  6'd0, 4'sd0);
      send_request(REQ_QUERY, 6'd0, 6'd0, 6'd0,  4'sd7);
      send_request(REQ_QUERY, 6'd0, 6'd0, 6'd63, -4'sd7);
      send_request(REQ_QUERY, 6'd0, 6'd0, 6'd1,  -4'sd8);
      send_request(REQ_QUERY, 6'd0, 6'd0, 6'd5,  4'sd0);
      // Dropped code with every actor field at its top value.
      send_request(REQ_UNUSED, 6'd63, 6'd63, 6'd63, -4'sd1);
      // Remove one tie: five left, not dense at six.
      send_request(REQ_CLEAR, 6'd63, 6'd0, 6'd0, 4'sd0);
      send_request(REQ_CLEAR, 6'd5,  6'd5, 6'd0, 4'sd0);
      send_request(REQ_QUERY, 6'd0, 6'd0, 6'd63, 4'sd1);

      // Five ties now qualify.
      wait_quiet();
      write_threshold(3'd5);
      send_request(REQ_QUERY, 6'd0, 6'd0, 6'd0, 4'sd7);
      send_request(REQ_QUERY, 6'd0, 6'd0, 6'd2, 4'sd7);

      // Seven can never be reached.
      wait_quiet();
      write_threshold(3'd7);
      send_request(REQ_QUERY, 6'd0, 6'd0, 6'd1, -4'sd3);

      // Random chunks under three idling regimes, each chunk at its own threshold.
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
         if (chunk == 0) begin
            send_idle_pct = 26;
            recv_idle_pct = 64;
         end else if (chunk == CHUNKS / 3) begin
            send_idle_pct = 64;
            recv_idle_pct = 26;
         end else if (chunk == 2 * CHUNKS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         wait_quiet();
         write_threshold(threshold_plan[chunk]);
         // Hold the response side off while queries keep coming, so the block backs up.
         if (chunk == 2 || chunk == 9) begin
            hold_off_len = HOLD_OFF_CYCLES;
            repeat (12)
               send_request(REQ_QUERY, any_actor(), any_actor(), pick_actor(),
                            random_difference());
         end
         chunk_end = requests_sent + CHUNK_REQUESTS;
         while (requests_sent < chunk_end) send_random_request();
      end

      wait_quiet();
      if (ledger.mismatches == 0) begin
         $display("tb_dense_triad_counter_unit: PASS");
      end else begin
         $display("tb_dense_triad_counter_unit: FAIL");
      end
      $finish;
   end

endmodule

FILE: dense_triad_counter_unit.f
rtl/dtc_pkg.sv
rtl/dtc_req_if.sv
rtl/dtc_rsp_if.sv
rtl/dtc_ram.sv
rtl/dtc_triad_lane.sv
rtl/dense_triad_counter_unit.sv
tb/tb_dense_triad_counter_unit.sv
